// File: sv/order_book_level_update_top_macros.svh
// assertion macros used by the checker file
`ifndef ORDER_BOOK_LEVEL_UPDATE_TOP_MACROS_SVH
`define ORDER_BOOK_LEVEL_UPDATE_TOP_MACROS_SVH

// same-cycle implication
`define OBLU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define OBLU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/oblu_pkg.sv
// shared constants, codes and types of the order book level update block
package oblu_pkg;

  localparam int unsigned MARKETS      = 256;
  localparam int unsigned PRICE_LEVELS = 4096;
  localparam int unsigned MKT_W        = $clog2(MARKETS);
  localparam int unsigned PL_W         = $clog2(PRICE_LEVELS);
  localparam int unsigned LVL_AW       = MKT_W + PL_W;
  localparam int unsigned LVL_DEPTH    = MARKETS * PRICE_LEVELS;
  localparam int unsigned QTY_W        = 31;
  localparam int unsigned SEQ_W        = 64;

  localparam logic [QTY_W-1:0] QTY_MAX = '1;

  localparam logic [1:0] SIDE_BID = 2'd0;
  localparam logic [1:0] SIDE_ASK = 2'd1;

  typedef enum logic [2:0] {
    OP_SNAP_START = 3'd0,
    OP_SNAP_LEVEL = 3'd1,
    OP_DELTA      = 3'd2,
    OP_TRADE      = 3'd3,
    OP_HEARTBEAT  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_STALE       = 3'd1,
    ST_BAD_LEVEL   = 3'd2,
    ST_BAD_SIDE    = 3'd3,
    ST_REJ_TYPE    = 3'd4,
    ST_UNK_TYPE    = 3'd5,
    ST_SNAP_ABORT  = 3'd6,
    ST_PRICE_RANGE = 3'd7
  } status_e;

  // per-market counters, open snapshot flag and last trade
  typedef struct packed {
    logic        snap_open;
    logic [31:0] stale_total;
    logic [31:0] reject_total;
    logic [31:0] snapshot_total;
    logic [31:0] delta_total;
    logic [31:0] trade_total;
    logic [31:0] last_trade_price;
    logic [31:0] last_trade_qty;
  } cnt_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic sweep_we;
    logic sweep_full;
    logic sweep_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic clear_req;
  } ctrl_stat_t;

endpackage

// File: sv/oblu_ram.sv
// generic single-port ram with registered read
module oblu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: sv/oblu_ctrl.sv
// sequencing state machine: reset sweep, read, execute, snapshot clear
module oblu_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  oblu_pkg::ctrl_stat_t   stat_i,
  output logic                   busy,
  output oblu_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_EXEC,
    S_CLEAR
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.sweep_we   = 1'b1;
        cmd_o.sweep_full = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = S_READ;
        end
      end
      S_READ: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (stat_i.clear_req) begin
          cmd_o.sweep_load = 1'b1;
          state_d          = S_CLEAR;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_CLEAR: begin
        cmd_o.sweep_we = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

// File: sv/oblu_dp.sv
// datapath: captured word, book memories, per-market state and result register
module oblu_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  oblu_pkg::ctrl_cmd_t            cmd_i,
  output oblu_pkg::ctrl_stat_t           stat_o,
  input  logic [2:0]                     op_i,
  input  logic [7:0]                     market_i,
  input  logic                           has_seq_i,
  input  logic [oblu_pkg::SEQ_W-1:0]     seq_i,
  input  logic [1:0]                     side_i,
  input  logic signed [31:0]             price_ticks_i,
  input  logic signed [31:0]             qty_i,
  input  logic                           last_level_i,
  output logic                           valid_o,
  output logic                           accepted_o,
  output logic [2:0]                     status_o,
  output logic [oblu_pkg::QTY_W-1:0]     level_qty_o
);

  // captured word
  logic [2:0]                     op_q;
  logic [7:0]                     market_q;
  logic                           has_seq_q;
  logic [oblu_pkg::SEQ_W-1:0]     seq_q;
  logic [1:0]                     side_q;
  logic signed [31:0]             price_q;
  logic signed [31:0]             qty_q;
  logic                           last_q;

  logic [oblu_pkg::MARKETS-1:0]   seq_seen_q;
  logic [oblu_pkg::LVL_AW-1:0]    sweep_q;

  logic [oblu_pkg::MKT_W-1:0]     mkt_idx;
  logic [oblu_pkg::LVL_AW-1:0]    lvl_addr;
  logic [oblu_pkg::QTY_W-1:0]     bid_rd, ask_rd, lvl_rd, lvl_wd;
  logic                           bid_we, ask_we;
  logic [oblu_pkg::SEQ_W-1:0]     lseq_rd;
  oblu_pkg::cnt_t                 cnt_rd, cnt_d, cnt_wd;
  logic [oblu_pkg::MKT_W-1:0]     cnt_addr;
  logic                           cnt_we;

  // execute decision
  logic                           in_range, stale, seq_upd;
  logic                           wr_lvl, cnt_upd, clear_req;
  logic                           acc_d;
  logic [2:0]                     st_d;
  logic [oblu_pkg::QTY_W-1:0]     q_d;
  logic signed [32:0]             sum;
  logic                           price_neg, price_big, qty_nonpos;

  logic                           valid_q, acc_q;
  logic [2:0]                     st_q;
  logic [oblu_pkg::QTY_W-1:0]     q_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= op_i;
      market_q  <= market_i;
      has_seq_q <= has_seq_i;
      seq_q     <= seq_i;
      side_q    <= side_i;
      price_q   <= price_ticks_i;
      qty_q     <= qty_i;
      last_q    <= last_level_i;
    end
  end

  assign mkt_idx  = market_q[oblu_pkg::MKT_W-1:0];
  assign lvl_addr = cmd_i.sweep_we ? sweep_q
                                   : {mkt_idx, price_q[oblu_pkg::PL_W-1:0]};
  assign lvl_rd   = (side_q == oblu_pkg::SIDE_BID) ? bid_rd : ask_rd;

  assign stat_o.sweep_last = cmd_i.sweep_full ? (&sweep_q)
                                              : (&sweep_q[oblu_pkg::PL_W-1:0]);
  assign stat_o.clear_req  = clear_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep_load) begin
      sweep_q <= {mkt_idx, {oblu_pkg::PL_W{1'b0}}};
    end else if (cmd_i.sweep_we) begin
      sweep_q <= sweep_q + 1'b1;
    end
  end

  assign in_range   = (32'(market_q) < oblu_pkg::MARKETS);
  assign stale      = has_seq_q && seq_seen_q[mkt_idx] && (seq_q <= lseq_rd);
  assign price_neg  = price_q[31];
  assign price_big  = |price_q[30:oblu_pkg::PL_W];
  assign qty_nonpos = qty_q[31] || (qty_q == 32'sd0);
  assign sum        = $signed({2'b00, lvl_rd}) + $signed({qty_q[31], qty_q});

  always_comb begin
    acc_d     = 1'b0;
    st_d      = oblu_pkg::ST_UNK_TYPE;
    q_d       = '0;
    seq_upd   = 1'b0;
    wr_lvl    = 1'b0;
    lvl_wd    = '0;
    cnt_upd   = 1'b0;
    clear_req = 1'b0;
    cnt_d     = cnt_rd;
    if (in_range) begin
      case (op_q)
        oblu_pkg::OP_SNAP_START: begin
          cnt_upd         = 1'b1;
          cnt_d.snap_open = 1'b0;
          if (stale) begin
            st_d                 = oblu_pkg::ST_STALE;
            cnt_d.stale_total    = cnt_rd.stale_total + 32'd1;
            cnt_d.reject_total   = cnt_rd.reject_total + 32'd1;
          end else begin
            seq_upd   = has_seq_q;
            clear_req = 1'b1;
            acc_d     = 1'b1;
            st_d      = oblu_pkg::ST_OK;
            if (last_q) begin
              cnt_d.snapshot_total = cnt_rd.snapshot_total + 32'd1;
            end else begin
              cnt_d.snap_open = 1'b1;
            end
          end
        end
        oblu_pkg::OP_SNAP_LEVEL: begin
          if (!cnt_rd.snap_open) begin
            st_d = oblu_pkg::ST_SNAP_ABORT;
          end else begin
            cnt_upd = 1'b1;
            if (side_q > oblu_pkg::SIDE_ASK) begin
              st_d = oblu_pkg::ST_BAD_SIDE;
            end else if (price_neg || qty_nonpos) begin
              st_d = oblu_pkg::ST_BAD_LEVEL;
            end else if (price_big) begin
              st_d = oblu_pkg::ST_PRICE_RANGE;
            end else begin
              st_d = oblu_pkg::ST_OK;
            end
            if (st_d != oblu_pkg::ST_OK) begin
              cnt_d.snap_open    = 1'b0;
              cnt_d.reject_total = cnt_rd.reject_total + 32'd1;
            end else begin
              acc_d  = 1'b1;
              wr_lvl = 1'b1;
              lvl_wd = qty_q[oblu_pkg::QTY_W-1:0];
              q_d    = qty_q[oblu_pkg::QTY_W-1:0];
              if (last_q) begin
                cnt_d.snap_open      = 1'b0;
                cnt_d.snapshot_total = cnt_rd.snapshot_total + 32'd1;
              end
            end
          end
        end
        oblu_pkg::OP_DELTA, oblu_pkg::OP_TRADE, oblu_pkg::OP_HEARTBEAT: begin
          cnt_upd = 1'b1;
          if (stale) begin
            st_d               = oblu_pkg::ST_STALE;
            cnt_d.stale_total  = cnt_rd.stale_total + 32'd1;
            cnt_d.reject_total = cnt_rd.reject_total + 32'd1;
          end else begin
            seq_upd = has_seq_q;
            if (op_q == oblu_pkg::OP_DELTA) begin
              if (price_neg) begin
                st_d = oblu_pkg::ST_BAD_LEVEL;
              end else if (price_big) begin
                st_d = oblu_pkg::ST_PRICE_RANGE;
              end else if (side_q > oblu_pkg::SIDE_ASK) begin
                st_d = oblu_pkg::ST_BAD_SIDE;
              end else begin
                st_d = oblu_pkg::ST_OK;
              end
              if (st_d != oblu_pkg::ST_OK) begin
                cnt_d.reject_total = cnt_rd.reject_total + 32'd1;
              end else begin
                // saturate the level sum to the field range
                if (sum <= 33'sd0) begin
                  lvl_wd = '0;
                end else if (sum > $signed({2'b00, oblu_pkg::QTY_MAX})) begin
                  lvl_wd = oblu_pkg::QTY_MAX;
                end else begin
                  lvl_wd = sum[oblu_pkg::QTY_W-1:0];
                end
                acc_d             = 1'b1;
                wr_lvl            = 1'b1;
                q_d               = lvl_wd;
                cnt_d.delta_total = cnt_rd.delta_total + 32'd1;
              end
            end else if (op_q == oblu_pkg::OP_TRADE) begin
              acc_d                  = 1'b1;
              st_d                   = oblu_pkg::ST_OK;
              cnt_d.last_trade_price = price_q;
              cnt_d.last_trade_qty   = qty_q;
              cnt_d.trade_total      = cnt_rd.trade_total + 32'd1;
            end else begin
              st_d               = oblu_pkg::ST_REJ_TYPE;
              cnt_d.reject_total = cnt_rd.reject_total + 32'd1;
            end
          end
        end
        default: begin
          st_d = oblu_pkg::ST_UNK_TYPE;
        end
      endcase
    end
  end

  assign bid_we = cmd_i.sweep_we ||
                  (cmd_i.exec && wr_lvl && (side_q == oblu_pkg::SIDE_BID));
  assign ask_we = cmd_i.sweep_we ||
                  (cmd_i.exec && wr_lvl && (side_q == oblu_pkg::SIDE_ASK));

  // full sweep after reset also zeroes the counters and snapshot flags
  assign cnt_we   = (cmd_i.sweep_we && cmd_i.sweep_full) || (cmd_i.exec && cnt_upd);
  assign cnt_wd   = cmd_i.sweep_we ? '0 : cnt_d;
  assign cnt_addr = cmd_i.sweep_we ? sweep_q[oblu_pkg::LVL_AW-1 -: oblu_pkg::MKT_W]
                                   : mkt_idx;

  oblu_ram #(.WIDTH(oblu_pkg::QTY_W), .DEPTH(oblu_pkg::LVL_DEPTH)) u_bid_ram (
    .clk_i   (clk_i),
    .we_i    (bid_we),
    .addr_i  (lvl_addr),
    .wdata_i (cmd_i.sweep_we ? '0 : lvl_wd),
    .rdata_o (bid_rd)
  );

  oblu_ram #(.WIDTH(oblu_pkg::QTY_W), .DEPTH(oblu_pkg::LVL_DEPTH)) u_ask_ram (
    .clk_i   (clk_i),
    .we_i    (ask_we),
    .addr_i  (lvl_addr),
    .wdata_i (cmd_i.sweep_we ? '0 : lvl_wd),
    .rdata_o (ask_rd)
  );

  oblu_ram #(.WIDTH(oblu_pkg::SEQ_W), .DEPTH(oblu_pkg::MARKETS)) u_seq_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.exec && seq_upd),
    .addr_i  (mkt_idx),
    .wdata_i (seq_q),
    .rdata_o (lseq_rd)
  );

  oblu_ram #(.WIDTH($bits(oblu_pkg::cnt_t)), .DEPTH(oblu_pkg::MARKETS)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .addr_i  (cnt_addr),
    .wdata_i (cnt_wd),
    .rdata_o (cnt_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_seen_q <= '0;
      valid_q    <= 1'b0;
    end else begin
      valid_q <= cmd_i.exec;
      if (cmd_i.exec && seq_upd) begin
        seq_seen_q[mkt_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      acc_q <= acc_d;
      st_q  <= st_d;
      q_q   <= q_d;
    end
  end

  assign valid_o     = valid_q;
  assign accepted_o  = acc_q;
  assign status_o    = st_q;
  assign level_qty_o = q_q;

endmodule

// File: sv/order_book_level_update_top.sv
// top level of the order book price level update block
//
// channel   direction  handshake                 word
// command   in         start high, busy low      op, market, seq, side, price, qty, flags
// result    out        valid_o strobe, 1 cycle   accepted, status, level_qty
//
// an item passes from accept to its result strobe through capture, memory read and
// execute with read-modify-write of one level entry and the per-market rams
// an accepted snapshot start additionally clears both sides of its market after it
// executes, one level row per cycle on the single port of each book memory
// after reset busy stays high while all MARKETS * PRICE_LEVELS book rows clear
// the result strobe cannot be held off; busy alone paces the command side
module order_book_level_update_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [2:0]                     op_i,
  input  logic [7:0]                     market_i,
  input  logic                           has_seq_i,
  input  logic [oblu_pkg::SEQ_W-1:0]     seq_i,
  input  logic [1:0]                     side_i,
  input  logic signed [31:0]             price_ticks_i,
  input  logic signed [31:0]             qty_i,
  input  logic                           last_level_i,
  output logic                           valid_o,
  output logic                           accepted_o,
  output logic [2:0]                     status_o,
  output logic [oblu_pkg::QTY_W-1:0]     level_qty_o
);

  oblu_pkg::ctrl_cmd_t  cmd;
  oblu_pkg::ctrl_stat_t stat;

  oblu_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  oblu_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .op_i          (op_i),
    .market_i      (market_i),
    .has_seq_i     (has_seq_i),
    .seq_i         (seq_i),
    .side_i        (side_i),
    .price_ticks_i (price_ticks_i),
    .qty_i         (qty_i),
    .last_level_i  (last_level_i),
    .valid_o       (valid_o),
    .accepted_o    (accepted_o),
    .status_o      (status_o),
    .level_qty_o   (level_qty_o)
  );

endmodule

// File: sv/oblu_checker.sv
// port-level checks on the top level, bound in below
`include "order_book_level_update_top_macros.svh"

module oblu_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       valid_o,
  input logic                       accepted_o,
  input logic [2:0]                 status_o,
  input logic [oblu_pkg::QTY_W-1:0] level_qty_o
);

  `OBLU_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `OBLU_ASSERT_NOW(a_acc_ok, clk_i, rst_ni, valid_o && accepted_o, status_o == oblu_pkg::ST_OK)
  `OBLU_ASSERT_NOW(a_rej_zero, clk_i, rst_ni, valid_o && !accepted_o, level_qty_o == '0)
  `OBLU_ASSERT_NOW(a_rej_status, clk_i, rst_ni, valid_o && !accepted_o, status_o != oblu_pkg::ST_OK)
  `OBLU_ASSERT_NEXT(a_single_strobe, clk_i, rst_ni, valid_o, !valid_o)

endmodule

bind order_book_level_update_top oblu_checker u_oblu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .valid_o     (valid_o),
  .accepted_o  (accepted_o),
  .status_o    (status_o),
  .level_qty_o (level_qty_o)
);

// File: tb/sv/tb_order_book_level_update_top.sv
// self-checking testbench of the order book price level update block
`timescale 1ns / 100ps

typedef struct {
  logic [2:0]         op;
  logic [7:0]         market;
  logic               has_seq;
  logic [63:0]        seq;
  logic [1:0]         side;
  logic signed [31:0] price;
  logic signed [31:0] qty;
  logic               last_level;
} book_cmd_t;

typedef struct {
  logic        accepted;
  logic [2:0]  status;
  logic [30:0] level_qty;
} book_res_t;

class book_scoreboard;
  bit          seq_valid[256];
  logic [63:0] seq_last[256];
  bit          snap_live[256];
  int unsigned bid_book[int];
  int unsigned ask_book[int];
  book_res_t   pending[$];
  int          fails;
  int          checked;

  // false when the event is stale
  function bit seq_ok(int m, logic has, logic [63:0] s);
    if (!has) return 1;
    if (seq_valid[m] && s <= seq_last[m]) return 0;
    seq_valid[m] = 1;
    seq_last[m]  = s;
    return 1;
  endfunction

  function void note_command(book_cmd_t c);
    book_res_t   r;
    int          m;
    int          key;
    longint      sum;
    int unsigned lvl;
    r = '{1'b0, oblu_pkg::ST_OK, 31'd0};
    m = c.market;
    key = m * oblu_pkg::PRICE_LEVELS + c.price;
    if (c.op > oblu_pkg::OP_HEARTBEAT || m >= oblu_pkg::MARKETS) begin
      r.status = oblu_pkg::ST_UNK_TYPE;
    end else if (c.op == oblu_pkg::OP_SNAP_START) begin
      snap_live[m] = 0;
      if (!seq_ok(m, c.has_seq, c.seq)) begin
        r.status = oblu_pkg::ST_STALE;
      end else begin
        for (int p = 0; p < oblu_pkg::PRICE_LEVELS; p++) begin
          bid_book.delete(m * oblu_pkg::PRICE_LEVELS + p);
          ask_book.delete(m * oblu_pkg::PRICE_LEVELS + p);
        end
        snap_live[m] = !c.last_level;
        r.accepted = 1;
      end
    end else if (c.op == oblu_pkg::OP_SNAP_LEVEL) begin
      if (!snap_live[m]) r.status = oblu_pkg::ST_SNAP_ABORT;
      else if (c.side > oblu_pkg::SIDE_ASK) r.status = oblu_pkg::ST_BAD_SIDE;
      else if (c.price < 0 || c.qty <= 0) r.status = oblu_pkg::ST_BAD_LEVEL;
      else if (c.price >= oblu_pkg::PRICE_LEVELS) r.status = oblu_pkg::ST_PRICE_RANGE;
      if (r.status == oblu_pkg::ST_OK) begin
        if (c.side == oblu_pkg::SIDE_BID) bid_book[key] = c.qty;
        else ask_book[key] = c.qty;
        if (c.last_level) snap_live[m] = 0;
        r.accepted  = 1;
        r.level_qty = c.qty[30:0];
      end else if (r.status != oblu_pkg::ST_SNAP_ABORT) begin
        snap_live[m] = 0;
      end
    end else if (!seq_ok(m, c.has_seq, c.seq)) begin
      r.status = oblu_pkg::ST_STALE;
    end else if (c.op == oblu_pkg::OP_DELTA) begin
      if (c.price < 0) r.status = oblu_pkg::ST_BAD_LEVEL;
      else if (c.price >= oblu_pkg::PRICE_LEVELS) r.status = oblu_pkg::ST_PRICE_RANGE;
      else if (c.side > oblu_pkg::SIDE_ASK) r.status = oblu_pkg::ST_BAD_SIDE;
      else begin
        if (c.side == oblu_pkg::SIDE_BID) lvl = bid_book.exists(key) ? bid_book[key] : 0;
        else lvl = ask_book.exists(key) ? ask_book[key] : 0;
        sum = longint'(lvl) + longint'(c.qty);
        if (sum < 0) sum = 0;
        else if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (c.side == oblu_pkg::SIDE_BID) bid_book[key] = 32'(sum);
        else ask_book[key] = 32'(sum);
        r.accepted  = 1;
        r.level_qty = sum[30:0];
      end
    end else if (c.op == oblu_pkg::OP_TRADE) begin
      r.accepted = 1;
    end else begin
      r.status = oblu_pkg::ST_REJ_TYPE;
    end
    pending.push_back(r);
  endfunction

  function void check_result(logic acc, logic [2:0] st, logic [30:0] q);
    book_res_t e;
    if (pending.size() == 0) begin
      $error("result word with nothing expected");
      fails++;
      return;
    end
    e = pending.pop_front();
    checked++;
    if (acc !== e.accepted) begin
      $error("accepted: expected %0d actual %0d", e.accepted, acc);
      fails++;
    end
    if (st !== e.status) begin
      $error("status: expected %0d actual %0d", e.status, st);
      fails++;
    end
    if (q !== e.level_qty) begin
      $error("level_qty: expected %0d actual %0d", e.level_qty, q);
      fails++;
    end
  endfunction
endclass

module tb_order_book_level_update_top;

  localparam logic [2:0] OP_UNKNOWN = 3'd5;
  localparam logic [1:0] SIDE_BAD   = 2'd2;
  localparam longint     CYCLE_LIMIT = 30_000_000;

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               start = 0;
  logic               busy;
  logic [2:0]         op_i = 0;
  logic [7:0]         market_i = 0;
  logic               has_seq_i = 0;
  logic [63:0]        seq_i = 0;
  logic [1:0]         side_i = 0;
  logic signed [31:0] price_ticks_i = 0;
  logic signed [31:0] qty_i = 0;
  logic               last_level_i = 0;
  logic               valid_o;
  logic               accepted_o;
  logic [2:0]         status_o;
  logic [30:0]        level_qty_o;

  book_scoreboard book = new();
  longint         cycles = 0;
  int             sent = 0;
  int             snaps_sent = 0;
  int             deltas_sent = 0;
  bit             quiet = 0;
  logic [63:0]    seq_hint[256];

  order_book_level_update_top dut (.*);

  initial forever #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && valid_o) book.check_result(accepted_o, status_o, level_qty_o);

  task automatic send_word(book_cmd_t c);
    while (!quiet && $urandom_range(0, 99) < 7) begin
      start = 0;
      @(negedge clk_i);
    end
    start = 1;
    op_i = c.op; market_i = c.market; has_seq_i = c.has_seq; seq_i = c.seq;
    side_i = c.side; price_ticks_i = c.price; qty_i = c.qty; last_level_i = c.last_level;
    // busy only moves at the rising edge, so a low value here means the next edge accepts
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    book.note_command(c);
    sent++;
    if (c.op == oblu_pkg::OP_SNAP_START) snaps_sent++;
    if (c.op == oblu_pkg::OP_DELTA) deltas_sent++;
    @(negedge clk_i);
    start = 0;
  endtask

  // mostly fresh sequence numbers, sometimes stale, rarely absent
  function automatic void pick_seq(ref book_cmd_t c);
    int r;
    r = $urandom_range(0, 99);
    c.has_seq = r >= 10;
    if (r < 85) begin
      c.seq = seq_hint[c.market] + $urandom_range(1, 5);
    end else begin
      c.seq = seq_hint[c.market] - $urandom_range(0, 3);
    end
    if (c.has_seq && c.seq > seq_hint[c.market]) seq_hint[c.market] = c.seq;
  endfunction

  function automatic logic signed [31:0] pick_price();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 15);
    if (r < 82) return $urandom_range(0, oblu_pkg::PRICE_LEVELS - 1);
    if (r < 88) return $urandom_range(0, 1) ? oblu_pkg::PRICE_LEVELS - 1
                                            : oblu_pkg::PRICE_LEVELS;
    if (r < 94) return -$urandom_range(1, 3);
    return $urandom;
  endfunction

  function automatic book_cmd_t blank(logic [2:0] op, logic [7:0] m);
    book_cmd_t c;
    c = '{op, m, 1'b0, 64'd0, oblu_pkg::SIDE_BID, 32'sd0, 32'sd0, 1'b0};
    return c;
  endfunction

  task automatic send_snapshot(logic [7:0] m);
    book_cmd_t c;
    int        n;
    c = blank(oblu_pkg::OP_SNAP_START, m);
    pick_seq(c);
    c.last_level = $urandom_range(0, 9) == 0;
    send_word(c);
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      c = blank(oblu_pkg::OP_SNAP_LEVEL, m);
      c.has_seq = 1'($urandom); c.seq = {$urandom, $urandom};
      c.side = 2'($urandom_range(0, 1));
      c.price = $urandom_range(0, 15);
      c.qty = $urandom_range(1, 5000);
      c.last_level = i == n - 1;
      // occasional broken level
      if ($urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 3))
          0: c.side = SIDE_BAD + 2'($urandom_range(0, 1));
          1: c.price = -$urandom_range(1, 100);
          2: c.price = oblu_pkg::PRICE_LEVELS + $urandom_range(0, 100);
          default: c.qty = -$urandom_range(0, 100);
        endcase
      end
      send_word(c);
    end
  endtask

  task automatic send_event(logic [7:0] m);
    book_cmd_t c;
    int        r;
    r = $urandom_range(0, 99);
    c = blank(oblu_pkg::OP_DELTA, m);
    if (r < 55) c.op = oblu_pkg::OP_DELTA;
    else if (r < 72) c.op = oblu_pkg::OP_TRADE;
    else if (r < 84) c.op = oblu_pkg::OP_HEARTBEAT;
    else if (r < 92) c.op = oblu_pkg::OP_SNAP_LEVEL;
    else c.op = OP_UNKNOWN + 3'($urandom_range(0, 2));
    pick_seq(c);
    c.side = $urandom_range(0, 9) == 0 ? SIDE_BAD + 2'($urandom_range(0, 1))
                                       : 2'($urandom_range(0, 1));
    c.price = pick_price();
    r = $urandom_range(0, 99);
    if (r < 65) c.qty = $urandom_range(0, 1) ? $urandom_range(1, 2000) : -$urandom_range(0, 1500);
    else if (r < 80) c.qty = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    else c.qty = $urandom;
    c.last_level = 1'($urandom);
    send_word(c);
  endtask

  initial begin
    book_cmd_t c;
    logic [7:0] m;
    repeat (2) @(negedge clk_i);
    rst_ni = 1;
    foreach (seq_hint[i]) seq_hint[i] = 0;

    // directed: extremes, every operation and the special cases
    c = blank(oblu_pkg::OP_SNAP_LEVEL, 8'd0); c.price = 1; c.qty = 5;
    send_word(c);  // no open snapshot
    c = blank(oblu_pkg::OP_SNAP_START, 8'd0); c.has_seq = 1; c.seq = 10; send_word(c);
    c = blank(oblu_pkg::OP_SNAP_LEVEL, 8'd0); c.price = 0; c.qty = 32'sh7fffffff;
    send_word(c);
    c = blank(oblu_pkg::OP_SNAP_LEVEL, 8'd0); c.side = oblu_pkg::SIDE_ASK;
    c.price = oblu_pkg::PRICE_LEVELS - 1; c.qty = 1; c.last_level = 1; send_word(c);
    c = blank(oblu_pkg::OP_DELTA, 8'd0); c.price = 0; c.qty = 32'sh7fffffff;
    send_word(c);  // saturates
    c = blank(oblu_pkg::OP_DELTA, 8'd0); c.side = oblu_pkg::SIDE_ASK;
    c.price = oblu_pkg::PRICE_LEVELS - 1; c.qty = 32'sh80000000;
    send_word(c);  // erases the level
    c = blank(oblu_pkg::OP_DELTA, 8'd0); c.price = 32'sh80000000; send_word(c);
    c = blank(oblu_pkg::OP_DELTA, 8'd0); c.price = oblu_pkg::PRICE_LEVELS; send_word(c);
    c = blank(oblu_pkg::OP_DELTA, 8'd0); c.side = 2'd3; c.price = 3; send_word(c);
    c = blank(oblu_pkg::OP_DELTA, 8'd0); c.has_seq = 1; c.seq = 10; send_word(c);  // stale
    c = blank(oblu_pkg::OP_TRADE, 8'd0); c.price = 32'sh80000000; c.qty = 32'sh7fffffff;
    send_word(c);
    c = blank(oblu_pkg::OP_HEARTBEAT, 8'd0); c.has_seq = 1; c.seq = 11; send_word(c);
    c = blank(OP_UNKNOWN, 8'd0); send_word(c);
    c = blank(3'd7, 8'hff); send_word(c);
    c = blank(oblu_pkg::OP_SNAP_START, 8'hff); c.has_seq = 1; c.seq = '1; send_word(c);
    c = blank(oblu_pkg::OP_SNAP_LEVEL, 8'hff); c.side = SIDE_BAD; send_word(c);  // aborts
    c = blank(oblu_pkg::OP_SNAP_LEVEL, 8'hff); c.price = 2; c.qty = 3; send_word(c);
    c = blank(oblu_pkg::OP_SNAP_START, 8'hff); c.has_seq = 1; c.seq = '1;
    send_word(c);  // stale
    c = blank(oblu_pkg::OP_SNAP_START, 8'hff); c.last_level = 1;
    send_word(c);  // empty snapshot
    c = blank(oblu_pkg::OP_SNAP_START, 8'd1); send_word(c);
    c = blank(oblu_pkg::OP_SNAP_LEVEL, 8'd1); c.price = 4; c.qty = 0; send_word(c);  // bad qty
    c = blank(oblu_pkg::OP_SNAP_START, 8'd1); send_word(c);
    c = blank(oblu_pkg::OP_SNAP_LEVEL, 8'd1); c.price = oblu_pkg::PRICE_LEVELS; c.qty = 9;
    send_word(c);
    seq_hint[0] = 11;

    while (sent < 1525) begin
      quiet = sent > 600 && sent < 900;
      if (sent > 750 && sent < 760) begin
        // hold off until the pipeline has drained
        while (book.pending.size() != 0) @(negedge clk_i);
      end
      m = $urandom_range(0, 9) == 0 ? 8'($urandom_range(4, 255)) : 8'($urandom_range(0, 3));
      if ($urandom_range(0, 99) < 3) begin
        // wide sequence numbers so the upper bits toggle
        c = blank(oblu_pkg::OP_HEARTBEAT, m); c.has_seq = 1; c.seq = {$urandom, $urandom};
        if (c.seq > seq_hint[m]) seq_hint[m] = c.seq;
        send_word(c);
      end else if ($urandom_range(0, 99) < 12) begin
        send_snapshot(m);
      end else begin
        send_event(m);
      end
    end

    while (book.pending.size() != 0) @(negedge clk_i);
    repeat (oblu_pkg::PRICE_LEVELS + 100) @(negedge clk_i);
    $display("run covered %0d words, %0d snapshot starts and %0d deltas, %0d results checked",
             sent, snaps_sent, deltas_sent, book.checked);
    if (book.fails == 0 && book.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
